### rtl/core/psp_pkg.sv
// Package: shared types and constants for the PAT section parser
`timescale 1ns / 1ps

package psp_pkg;

    localparam int unsigned EVQ_DEPTH   = 4;
    localparam int unsigned POS_W       = 13;
    localparam int unsigned LEN_W       = 12;
    localparam int unsigned LEFT_W      = 10;
    localparam int unsigned GATHER_W    = 24;

    localparam logic [POS_W-1:0] POS_TABLE_ID  = 13'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 13'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 13'd2;
    localparam logic [POS_W-1:0] POS_TSID_HI   = 13'd3;
    localparam logic [POS_W-1:0] POS_TSID_LO   = 13'd4;
    localparam logic [POS_W-1:0] POS_VERSION   = 13'd5;
    localparam logic [POS_W-1:0] POS_SECT_NUM  = 13'd6;
    localparam logic [POS_W-1:0] POS_LAST_SECT = 13'd7;

    localparam logic [1:0]       PHASE_LAST    = 2'd3;
    localparam logic [LEN_W-1:0] HDR_MIN_LEN   = 12'd9;

    typedef struct packed {
        logic [15:0] stream_id;
        logic [4:0]  version;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  final_section_index;
    } t_hdr;

    typedef struct packed {
        logic        has_entry;
        logic        has_end;
        logic        trunc;
        logic [31:0] word;
        t_hdr        hdr;
    } t_event;

    typedef struct packed {
        logic [15:0] prog_num;
        logic [12:0] program_pid;
        t_hdr        hdr;
        logic [31:0] crc_field;
        logic        truncated;
        logic        last;
    } t_result;

endpackage

### rtl/core/psp_front.sv
// Front end: byte intake, section header capture and entry framing
`timescale 1ns / 1ps

module psp_front
    import psp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_section_byte,
    input  logic         i_section_start,
    input  logic         i_buffer_last,
    output logic         o_ev_valid,
    output t_event       o_ev
);

    logic [POS_W-1:0]    r_pos,    n_pos;
    logic                r_active, n_active;
    logic [LEN_W-1:0]    r_len,    n_len;
    logic [LEFT_W-1:0]   r_left,   n_left;
    t_hdr                r_hdr,    n_hdr;
    logic [GATHER_W-1:0] r_gather, n_gather;

    logic [POS_W-1:0]    c_pos;
    logic                c_active;
    logic [LEN_W-1:0]    c_len;
    logic [LEFT_W-1:0]   c_left;
    t_hdr                c_hdr;
    logic [GATHER_W-1:0] c_gather;
    logic [LEN_W-1:0]    len_full;
    logic [LEN_W-1:0]    len_diff;
    logic [31:0]         word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_active <= 1'b0;
            r_len    <= '0;
            r_left   <= '0;
            r_hdr    <= '0;
            r_gather <= '0;
        end else begin
            r_pos    <= n_pos;
            r_active <= n_active;
            r_len    <= n_len;
            r_left   <= n_left;
            r_hdr    <= n_hdr;
            r_gather <= n_gather;
        end
    end

    always_comb begin
        c_pos    = i_section_start ? '0 : r_pos;
        c_active = i_section_start | r_active;
        c_len    = i_section_start ? '0 : r_len;
        c_left   = i_section_start ? '0 : r_left;
        c_hdr    = i_section_start ? '0 : r_hdr;
        c_gather = i_section_start ? '0 : r_gather;
        len_full = {c_len[LEN_W-1:8], i_section_byte};
        len_diff = len_full - HDR_MIN_LEN;
        word     = {c_gather, i_section_byte};

        n_pos    = r_pos;
        n_active = r_active;
        n_len    = r_len;
        n_left   = r_left;
        n_hdr    = r_hdr;
        n_gather = r_gather;
        o_ev     = '0;

        if (i_accept && c_active) begin
            n_active = 1'b1;
            n_len    = c_len;
            n_left   = c_left;
            n_hdr    = c_hdr;
            n_gather = c_gather;
            unique case (c_pos)
                POS_TABLE_ID: begin
                end
                POS_LEN_HI: begin
                    n_len = {i_section_byte[3:0], 8'h00};
                end
                POS_LEN_LO: begin
                    n_len  = len_full;
                    n_left = (len_full < HDR_MIN_LEN) ? '0 : len_diff[LEN_W-1:2];
                end
                POS_TSID_HI:   n_hdr.stream_id[15:8]       = i_section_byte;
                POS_TSID_LO:   n_hdr.stream_id[7:0]        = i_section_byte;
                POS_VERSION: begin
                    n_hdr.version      = i_section_byte[5:1];
                    n_hdr.current_next = i_section_byte[0];
                end
                POS_SECT_NUM:  n_hdr.section_index       = i_section_byte;
                POS_LAST_SECT: n_hdr.final_section_index = i_section_byte;
                default: begin
                    if (c_pos[1:0] == PHASE_LAST) begin
                        o_ev.word = word;
                        n_gather  = '0;
                        if (c_left != '0) begin
                            o_ev.has_entry = 1'b1;
                            n_left         = c_left - 1'b1;
                        end else begin
                            o_ev.has_end = 1'b1;
                            n_active     = 1'b0;
                        end
                    end else begin
                        n_gather = {c_gather[GATHER_W-9:0], i_section_byte};
                    end
                end
            endcase
            n_pos = c_pos + 1'b1;
            if (i_buffer_last && n_active) begin
                o_ev.has_end = 1'b1;
                o_ev.trunc   = 1'b1;
                n_active     = 1'b0;
            end
            o_ev.hdr = n_hdr;
        end
        o_ev_valid = o_ev.has_entry | o_ev.has_end;
    end

endmodule

### rtl/core/psp_evq.sv
// Event queue between the front end and the result stage
`timescale 1ns / 1ps

module psp_evq
    import psp_pkg::*;
#(
    parameter int unsigned DEPTH = EVQ_DEPTH
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_event i_ev,
    input  logic   i_rd,
    output t_event o_head,
    output logic   o_nonempty,
    output logic   o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt,    n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CNT_FULL);

endmodule

### rtl/core/psp_back.sv
// Result stage: expands queued events into result words
`timescale 1ns / 1ps

module psp_back
    import psp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_event  i_head,
    input  logic    i_nonempty,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    logic    r_sub,   n_sub;
    t_result r_res,   n_res;
    logic    take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        take    = !r_valid || i_pop;
        n_valid = r_valid;
        n_sub   = r_sub;
        n_res   = r_res;
        o_q_rd  = 1'b0;
        if (take) begin
            n_valid = i_nonempty;
            if (i_nonempty) begin
                n_res     = '0;
                n_res.hdr = i_head.hdr;
                if (i_head.has_entry && !r_sub) begin
                    n_res.prog_num    = i_head.word[31:16];
                    n_res.program_pid = i_head.word[12:0];
                    if (i_head.has_end) begin
                        n_sub = 1'b1;
                    end else begin
                        o_q_rd = 1'b1;
                    end
                end else begin
                    n_res.crc_field = i_head.trunc ? '0 : i_head.word;
                    n_res.truncated = i_head.trunc;
                    n_res.last      = 1'b1;
                    n_sub           = 1'b0;
                    o_q_rd          = 1'b1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/core/pat_section_parser.sv
// Top level: program association section parser
// A byte's event is queued when accepted and later registered by the result stage.
// Throughput: one byte per cycle while full is low; one result word per cycle while
//   pop allows, so a byte that yields an entry and a truncated end gives two words.
// The event queue (QUEUE_DEPTH words) absorbs output stalls before full rises.
// Reset: synchronous active low; clears parser state, queue and output stage.
`timescale 1ns / 1ps

module pat_section_parser
    import psp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = EVQ_DEPTH
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_section_byte,
    input  logic        i_section_start,
    input  logic        i_buffer_last,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_prog_num,
    output logic [12:0] o_program_pid,
    output logic [15:0] o_stream_id,
    output logic [4:0]  o_version,
    output logic        o_current_next,
    output logic [7:0]  o_section_index,
    output logic [7:0]  o_final_section_index,
    output logic [31:0] o_crc_field,
    output logic        o_truncated,
    output logic        o_last
);

    logic    accept;
    logic    ev_valid;
    t_event  ev;
    t_event  head;
    logic    nonempty;
    logic    q_full;
    logic    q_rd;
    logic    res_valid;
    t_result res;

    assign accept = push && !q_full;
    assign full   = q_full;

    psp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_section_byte  (i_section_byte),
        .i_section_start (i_section_start),
        .i_buffer_last   (i_buffer_last),
        .o_ev_valid      (ev_valid),
        .o_ev            (ev)
    );

    psp_evq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (ev_valid),
        .i_ev       (ev),
        .i_rd       (q_rd),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_full     (q_full)
    );

    psp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_nonempty (nonempty),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_valid    (res_valid),
        .o_res      (res)
    );

    assign empty                 = !res_valid;
    assign o_prog_num            = res.prog_num;
    assign o_program_pid         = res.program_pid;
    assign o_stream_id           = res.hdr.stream_id;
    assign o_version             = res.hdr.version;
    assign o_current_next        = res.hdr.current_next;
    assign o_section_index       = res.hdr.section_index;
    assign o_final_section_index = res.hdr.final_section_index;
    assign o_crc_field           = res.crc_field;
    assign o_truncated           = res.truncated;
    assign o_last                = res.last;

endmodule

### rtl/core/psp_checker.sv
// Checker: port-level assertions for the PAT section parser, bound to the top level
`timescale 1ns / 1ps

module psp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        empty,
    input  logic [15:0] o_prog_num,
    input  logic [12:0] o_program_pid,
    input  logic [31:0] o_crc_field,
    input  logic        o_truncated,
    input  logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_end_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_prog_num == 16'd0 && o_program_pid == 13'd0))
        else $error("end word carries entry fields");

    a_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_crc_field == 32'd0 && !o_truncated))
        else $error("entry word carries end fields");

    a_trunc_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_truncated) |-> (o_last && o_crc_field == 32'd0))
        else $error("truncated word is not a bare end word");

endmodule

bind pat_section_parser psp_checker u_psp_checker (.*);

### tb/sv/tb_pat_section_parser.sv
// Testbench for pat_section_parser: directed table, random sections, and a byte-level predictor
`timescale 1ns / 1ps

module tb_pat_section_parser;
    import psp_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 800;
    localparam int PREDICTED    = -1;
    localparam int MAX_REPORTS  = 40;

    localparam t_result ZERO_TRUNC_END = '{prog_num: '0, program_pid: '0, hdr: '0,
                                           crc_field: '0, truncated: 1'b1, last: 1'b1};
    localparam t_result ALL_ONES_ENTRY = '{prog_num: 16'hFFFF, program_pid: 13'h1FFF,
                                           hdr: '1, crc_field: '0, truncated: 1'b0,
                                           last: 1'b0};
    localparam t_result ALL_ONES_END   = '{prog_num: '0, program_pid: '0, hdr: '1,
                                           crc_field: 32'hFFFF_FFFF, truncated: 1'b0,
                                           last: 1'b1};

    typedef struct {
        logic [7:0] b;
        bit         st;
        bit         bl;
        int         n_known;
        t_result    known;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_section_byte = '0;
    logic        i_section_start = 1'b0;
    logic        i_buffer_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_prog_num;
    logic [12:0] o_program_pid;
    logic [15:0] o_stream_id;
    logic [4:0]  o_version;
    logic        o_current_next;
    logic [7:0]  o_section_index;
    logic [7:0]  o_final_section_index;
    logic [31:0] o_crc_field;
    logic        o_truncated;
    logic        o_last;

    pat_section_parser dut (.*);

    // section parser prediction state
    logic [POS_W-1:0]  sec_pos = '0;
    bit                sec_open = 1'b0;
    logic [LEN_W-1:0]  sec_len = '0;
    logic [LEFT_W-1:0] progs_left = '0;
    t_hdr              sec_hdr = '0;
    logic [23:0]       entry_gather = '0;
    bit                byte_taken;

    t_result new_results[$];
    t_result pending_words[$];

    int  errors = 0;
    int  bytes_taken = 0;
    int  entries_seen = 0;
    int  ends_seen = 0;
    int  cut_seen = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;

    t_row script [25] = '{
        '{8'h5A, 1'b0, 1'b1, 0, '0},
        '{8'h00, 1'b1, 1'b1, 1, ZERO_TRUNC_END},
        '{8'h00, 1'b1, 1'b0, PREDICTED, '0},
        '{8'hF0, 1'b0, 1'b0, PREDICTED, '0},
        '{8'h0D, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, 1, ALL_ONES_ENTRY},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b0, PREDICTED, '0},
        '{8'hFF, 1'b0, 1'b1, 1, ALL_ONES_END},
        '{8'h77, 1'b0, 1'b0, 0, '0},
        '{8'h00, 1'b1, 1'b0, PREDICTED, '0},
        '{8'h00, 1'b0, 1'b0, PREDICTED, '0},
        '{8'h05, 1'b0, 1'b0, PREDICTED, '0},
        '{8'h80, 1'b1, 1'b0, PREDICTED, '0},
        '{8'hF0, 1'b0, 1'b0, PREDICTED, '0},
        '{8'h08, 1'b0, 1'b1, PREDICTED, '0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
            $display("pat_section_parser verification failed");
            $finish;
        end
    end

    task automatic parse_byte(input logic [7:0] b, input bit st, input bit bl);
        logic [31:0]      word;
        logic [POS_W-1:0] rel;
        logic [LEN_W-1:0] span;
        t_result          res;
        if (st) begin
            sec_pos      = '0;
            sec_len      = '0;
            progs_left   = '0;
            sec_hdr      = '0;
            entry_gather = '0;
            sec_open     = 1'b1;
        end
        byte_taken = sec_open;
        if (!sec_open) return;
        rel = sec_pos - 13'd8;
        case (sec_pos)
            POS_TABLE_ID: ;
            POS_LEN_HI: sec_len = {b[3:0], 8'h00};
            POS_LEN_LO: begin
                sec_len[7:0] = sec_len[7:0] | b;
                span = (sec_len - HDR_MIN_LEN) >> 2;
                progs_left = (sec_len < HDR_MIN_LEN) ? '0 : span[LEFT_W-1:0];
            end
            POS_TSID_HI: sec_hdr.stream_id[15:8] |= b;
            POS_TSID_LO: sec_hdr.stream_id[7:0] |= b;
            POS_VERSION: begin
                sec_hdr.version      |= b[5:1];
                sec_hdr.current_next |= b[0];
            end
            POS_SECT_NUM: sec_hdr.section_index |= b;
            POS_LAST_SECT: sec_hdr.final_section_index |= b;
            default: begin
                if (rel[1:0] == PHASE_LAST) begin
                    word = {entry_gather, b};
                    res = '0;
                    res.hdr = sec_hdr;
                    if (progs_left != '0) begin
                        res.prog_num    = word[31:16];
                        res.program_pid = word[12:0];
                        progs_left      = progs_left - 1'b1;
                    end else begin
                        res.crc_field = word;
                        res.last      = 1'b1;
                        sec_open      = 1'b0;
                    end
                    new_results.push_back(res);
                    entry_gather = '0;
                end else begin
                    entry_gather = {entry_gather[15:0], b};
                end
            end
        endcase
        sec_pos = sec_pos + 1'b1;
        if (bl && sec_open) begin
            res = '0;
            res.hdr       = sec_hdr;
            res.truncated = 1'b1;
            res.last      = 1'b1;
            new_results.push_back(res);
            sec_open = 1'b0;
        end
    endtask

    task automatic send_word(input logic [7:0] b, input bit st, input bit bl,
                             input int n_known, input t_result known);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_section_byte  <= b;
        i_section_start <= st;
        i_buffer_last   <= bl;
        do @(posedge i_clk); while (full !== 1'b0);
        parse_byte(b, st, bl);
        if (n_known == PREDICTED) begin
            foreach (new_results[k]) pending_words.push_back(new_results[k]);
        end else begin
            repeat (n_known) pending_words.push_back(known);
        end
        new_results.delete();
        if (byte_taken) bytes_taken++;
    endtask

    task automatic send_random_chunk();
        logic [7:0]       hdr_bytes[$];
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] span;
        int               pick;
        int               n_prog;
        int               size;
        int               cut;
        pick = $urandom_range(0, 99);
        calm = ($urandom_range(0, 6) == 0);
        if (pick >= 93) begin
            repeat ($urandom_range(1, 5))
                send_word(8'($urandom), ($urandom_range(0, 9) == 0),
                          1'($urandom_range(0, 1)), PREDICTED, '0);
            return;
        end
        if (pick >= 70) len = 12'($urandom);
        else if ($urandom_range(0, 9) == 0) len = 12'($urandom_range(0, 8));
        else len = 12'(9 + 4 * $urandom_range(0, 4) + $urandom_range(0, 3));
        span = (len - HDR_MIN_LEN) >> 2;
        n_prog = (len < HDR_MIN_LEN) ? 0 : int'(span);
        if (n_prog > 8) n_prog = 8;
        size = 8 + 4 * n_prog + 4;
        hdr_bytes.push_back(8'($urandom));
        hdr_bytes.push_back({4'($urandom), len[11:8]});
        hdr_bytes.push_back(len[7:0]);
        repeat (size - 3) hdr_bytes.push_back(8'($urandom));
        if (pick < 70) begin
            foreach (hdr_bytes[k])
                send_word(hdr_bytes[k], (k == 0),
                          (k == size - 1) && ($urandom_range(0, 1) == 1), PREDICTED, '0);
            if ($urandom_range(0, 9) < 3)
                repeat ($urandom_range(1, 3))
                    send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), PREDICTED, '0);
        end else begin
            cut = $urandom_range(0, size - 2);
            for (int k = 0; k <= cut; k++)
                send_word(hdr_bytes[k], (k == 0), (pick < 85) && (k == cut), PREDICTED, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_word();
        t_result want;
        if (pending_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected word, expected none actual last=%0b pid=%0h",
                         $time, o_last, o_program_pid);
            return;
        end
        want = pending_words.pop_front();
        check_field("prog_num", 32'(want.prog_num), 32'(o_prog_num));
        check_field("program_pid", 32'(want.program_pid), 32'(o_program_pid));
        check_field("stream_id", 32'(want.hdr.stream_id), 32'(o_stream_id));
        check_field("version", 32'(want.hdr.version), 32'(o_version));
        check_field("current_next", 32'(want.hdr.current_next), 32'(o_current_next));
        check_field("section_index", 32'(want.hdr.section_index), 32'(o_section_index));
        check_field("final_section_index", 32'(want.hdr.final_section_index),
                    32'(o_final_section_index));
        check_field("crc_field", want.crc_field, o_crc_field);
        check_field("truncated", 32'(want.truncated), 32'(o_truncated));
        check_field("last", 32'(want.last), 32'(o_last));
        if (!want.last) entries_seen++;
        else ends_seen++;
        if (want.truncated) cut_seen++;
    endtask

    initial begin : result_side
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && empty === 1'b0) begin
                check_word();
                stall = calm ? 0 : $urandom_range(0, 10);
            end else if (stall > 0) begin
                stall--;
            end
            if (hold_left > 0) hold_left--;
            pop <= (stall == 0) && (hold_left == 0) && i_rst_n;
        end
    end

    initial begin : byte_side
        bit squeezed;
        squeezed = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r])
            send_word(script[r].b, script[r].st, script[r].bl, script[r].n_known,
                      script[r].known);

        while (bytes_taken < RANDOM_BYTES + 25) begin
            if (!squeezed && bytes_taken > 300) begin
                squeezed  = 1'b1;
                hold_left = 400;
            end
            send_random_chunk();
        end
        push <= 1'b0;
        calm = 1'b0;

        while (pending_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d section bytes: %0d program entries and %0d section ends,",
                 bytes_taken, entries_seen, ends_seen);
        $display("%0d of them cut short, with restarts, noise and a long output stall.",
                 cut_seen);
        if (errors == 0) begin
            $display("pat_section_parser verification clean");
        end else begin
            $display("pat_section_parser verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/psp_pkg.sv
rtl/core/psp_front.sv
rtl/core/psp_evq.sv
rtl/core/psp_back.sv
rtl/core/pat_section_parser.sv
rtl/core/psp_checker.sv
tb/sv/tb_pat_section_parser.sv
